// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// checked through reset as well
`define ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: src/fnab_pkg.sv
package fnab_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int PIXEL_BITS = 8;

   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int USED_W_BITS = COL_BITS + 1;
   localparam int USED_H_BITS = ROW_BITS + 1;

   localparam int AVG_SHIFT = 2;
   localparam int SUM_BITS  = PIXEL_BITS + AVG_SHIFT;

   localparam int WIDTH_REG_BITS  = 12;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int CSR_DATA_BITS   = (WIDTH_REG_BITS > HEIGHT_REG_BITS) ?
                                    WIDTH_REG_BITS : HEIGHT_REG_BITS;
   localparam int CSR_INDEX_BITS  = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [WIDTH_REG_BITS-1:0]  RESET_FRAME_WIDTH  = 12'd1920;
   localparam logic [HEIGHT_REG_BITS-1:0] RESET_FRAME_HEIGHT = 13'd1080;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // what the front works out for each pixel
   typedef struct packed {
      logic emit_up_row;   // row above is complete at this column
      logic emit_behind;   // last row, pixel one column back
      logic emit_final;    // last pixel of the frame
      logic col_ge1;
      logic col_ge2;
      logic has_right;
      logic row_ge2;
      logic tall;          // frame has two rows or more
   } item_flags_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [ROW_BITS-1:0]   row;
      logic [COL_BITS-1:0]   col;
      item_flags_type        flags;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } item_xfer_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [ROW_BITS-1:0]   row;
      logic [COL_BITS-1:0]   col;
      logic                  frame_end;
   } result_type;

endpackage

// File: src/fnab_ram.sv
module fnab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/fnab_front.sv
module fnab_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fnab_pkg::PIXEL_BITS-1:0]     req_pixel_in,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fnab_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fnab_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                q_full,
   output fnab_pkg::item_xfer_type             q_push
);

   function automatic logic [fnab_pkg::USED_W_BITS-1:0] clamp_width(
      input logic [fnab_pkg::WIDTH_REG_BITS-1:0] v);
      logic [fnab_pkg::USED_W_BITS-1:0] x;
      if (v == '0) begin
         x = fnab_pkg::USED_W_BITS'(1);
      end else if (32'(v) > 32'(fnab_pkg::MAX_WIDTH)) begin
         x = fnab_pkg::USED_W_BITS'(fnab_pkg::MAX_WIDTH);
      end else begin
         x = fnab_pkg::USED_W_BITS'(v);
      end
      return x;
   endfunction

   function automatic logic [fnab_pkg::USED_H_BITS-1:0] clamp_height(
      input logic [fnab_pkg::HEIGHT_REG_BITS-1:0] v);
      logic [fnab_pkg::USED_H_BITS-1:0] x;
      if (v == '0) begin
         x = fnab_pkg::USED_H_BITS'(1);
      end else if (32'(v) > 32'(fnab_pkg::MAX_HEIGHT)) begin
         x = fnab_pkg::USED_H_BITS'(fnab_pkg::MAX_HEIGHT);
      end else begin
         x = fnab_pkg::USED_H_BITS'(v);
      end
      return x;
   endfunction

   logic [fnab_pkg::WIDTH_REG_BITS-1:0]  width_ff, width_in;
   logic [fnab_pkg::HEIGHT_REG_BITS-1:0] height_ff, height_in;
   logic [fnab_pkg::COL_BITS-1:0]        col_ff, col_in;
   logic [fnab_pkg::ROW_BITS-1:0]        row_ff, row_in;

   logic [fnab_pkg::USED_W_BITS-1:0] used_w, col_next;
   logic [fnab_pkg::USED_H_BITS-1:0] used_h, row_next;
   logic                             accept, last_col, last_row, row_ge1;
   fnab_pkg::item_flags_type         flags;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign used_w   = clamp_width(width_ff);
   assign used_h   = clamp_height(height_ff);
   assign col_next = fnab_pkg::USED_W_BITS'(col_ff) + fnab_pkg::USED_W_BITS'(1);
   assign row_next = fnab_pkg::USED_H_BITS'(row_ff) + fnab_pkg::USED_H_BITS'(1);
   assign last_col = (col_next == used_w);
   assign last_row = (row_next == used_h);
   assign row_ge1  = (row_ff != '0);

   always_comb begin
      flags.emit_up_row = row_ge1;
      flags.emit_behind = last_row && (col_ff != '0);
      flags.emit_final  = last_row && last_col;
      flags.col_ge1     = (col_ff != '0);
      flags.col_ge2     = (col_ff[fnab_pkg::COL_BITS-1:1] != '0);
      flags.has_right   = !last_col;
      flags.row_ge2     = (row_ff[fnab_pkg::ROW_BITS-1:1] != '0);
      flags.tall        = (used_h[fnab_pkg::USED_H_BITS-1:1] != '0);
   end

   always_comb begin
      q_push.valid      = accept;
      q_push.item.pixel = req_pixel_in;
      q_push.item.row   = row_ff;
      q_push.item.col   = col_ff;
      q_push.item.flags = flags;
   end

   // a write to frame_width or frame_height restarts the frame
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            fnab_pkg::CSR_FRAME_WIDTH: begin
               width_in = csr_wdata[fnab_pkg::WIDTH_REG_BITS-1:0];
               col_in   = '0;
               row_in   = '0;
            end
            fnab_pkg::CSR_FRAME_HEIGHT: begin
               height_in = csr_wdata[fnab_pkg::HEIGHT_REG_BITS-1:0];
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[fnab_pkg::ROW_BITS-1:0];
         end else begin
            col_in = col_next[fnab_pkg::COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= fnab_pkg::RESET_FRAME_WIDTH;
         height_ff <= fnab_pkg::RESET_FRAME_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

// File: src/fnab_queue.sv
module fnab_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  fnab_pkg::item_xfer_type push,
   output logic                    full,
   input  logic                    pop,
   output fnab_pkg::item_xfer_type head
);

   fnab_pkg::item_type                  slot_ff [fnab_pkg::QUEUE_DEPTH];
   logic [fnab_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fnab_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fnab_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full       = (count_ff == (fnab_pkg::QUEUE_PTR_BITS+1)'(fnab_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/fnab_back.sv
module fnab_back (
   input  logic                    clock,
   input  logic                    reset,
   input  fnab_pkg::item_xfer_type head,
   output logic                    pop,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output fnab_pkg::result_type    rsp_data
);

   localparam int RES_UP_ROW = 0;
   localparam int RES_BEHIND = 1;
   localparam int RES_FINAL  = 2;
   localparam int RES_COUNT  = 3;

   localparam int PB = fnab_pkg::PIXEL_BITS;
   localparam int CB = fnab_pkg::COL_BITS;

   logic               b_valid_ff, b_valid_in;
   fnab_pkg::item_type b_item_ff, b_item_in;
   logic [RES_COUNT-1:0] sent_ff, sent_in;

   // same-cycle write forwarding, captured when an item enters
   logic          byp_centre_ff, byp_centre_in;
   logic          byp_above_ff, byp_above_in;
   logic          byp_right_ff, byp_right_in;
   logic [PB-1:0] byp_centre_val_ff, byp_centre_val_in;
   logic [PB-1:0] byp_above_val_ff, byp_above_val_in;
   logic [PB-1:0] byp_right_val_ff, byp_right_val_in;

   logic [PB-1:0] prev_centre_ff, prev_centre_in;
   logic [PB-1:0] prev_pixel_ff, prev_pixel_in;
   logic [PB-1:0] prev2_pixel_ff, prev2_pixel_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   fnab_pkg::result_type rsp_data_ff, rsp_data_in;

   logic          issue, b_leave, take, out_ready;
   logic [CB-1:0] head_right_addr;
   logic [PB-1:0] newer_c_rd, newer_r_rd, older_rd;
   logic [PB-1:0] centre, above, right_raw, p;
   logic [RES_COUNT-1:0] mask, pending, sel_bit, remaining;
   logic [PB-1:0] n_left, n_right, n_up, n_down;
   logic [fnab_pkg::SUM_BITS-1:0] sum;
   fnab_pkg::result_type          res;

   assign issue           = head.valid && (!b_valid_ff || b_leave);
   assign pop             = issue;
   assign head_right_addr = head.item.col + 1'b1;

   // newer row is kept twice so that columns c and c+1 read together
   fnab_ram #(.WIDTH(PB), .DEPTH(fnab_pkg::MAX_WIDTH)) u_newer_c (
      .clock   (clock),
      .wr_en   (b_leave),
      .wr_addr (b_item_ff.col),
      .wr_data (b_item_ff.pixel),
      .rd_en   (issue),
      .rd_addr (head.item.col),
      .rd_data (newer_c_rd)
   );

   fnab_ram #(.WIDTH(PB), .DEPTH(fnab_pkg::MAX_WIDTH)) u_newer_r (
      .clock   (clock),
      .wr_en   (b_leave),
      .wr_addr (b_item_ff.col),
      .wr_data (b_item_ff.pixel),
      .rd_en   (issue),
      .rd_addr (head_right_addr),
      .rd_data (newer_r_rd)
   );

   fnab_ram #(.WIDTH(PB), .DEPTH(fnab_pkg::MAX_WIDTH)) u_older (
      .clock   (clock),
      .wr_en   (b_leave),
      .wr_addr (b_item_ff.col),
      .wr_data (centre),
      .rd_en   (issue),
      .rd_addr (head.item.col),
      .rd_data (older_rd)
   );

   assign p         = b_item_ff.pixel;
   assign centre    = byp_centre_ff ? byp_centre_val_ff : newer_c_rd;
   assign above     = byp_above_ff ? byp_above_val_ff : older_rd;
   assign right_raw = byp_right_ff ? byp_right_val_ff : newer_r_rd;

   assign mask[RES_UP_ROW] = b_item_ff.flags.emit_up_row;
   assign mask[RES_BEHIND] = b_item_ff.flags.emit_behind;
   assign mask[RES_FINAL]  = b_item_ff.flags.emit_final;
   assign pending          = mask & ~sent_ff;

   // results go out in order: row above, one column behind, frame end
   always_comb begin
      sel_bit = '0;
      if (pending[RES_UP_ROW]) begin
         sel_bit[RES_UP_ROW] = 1'b1;
      end else if (pending[RES_BEHIND]) begin
         sel_bit[RES_BEHIND] = 1'b1;
      end else begin
         sel_bit[RES_FINAL] = 1'b1;
      end
   end

   always_comb begin
      res.row       = b_item_ff.row;
      res.col       = b_item_ff.col;
      res.frame_end = 1'b0;
      if (sel_bit[RES_UP_ROW]) begin
         n_left  = b_item_ff.flags.col_ge1 ? prev_centre_ff : centre;
         n_right = b_item_ff.flags.has_right ? right_raw : centre;
         n_up    = b_item_ff.flags.row_ge2 ? above : centre;
         n_down  = p;
         res.row = b_item_ff.row - 1'b1;
      end else if (sel_bit[RES_BEHIND]) begin
         n_left  = b_item_ff.flags.col_ge2 ? prev2_pixel_ff : prev_pixel_ff;
         n_right = p;
         n_up    = b_item_ff.flags.tall ? prev_centre_ff : prev_pixel_ff;
         n_down  = prev_pixel_ff;
         res.col = b_item_ff.col - 1'b1;
      end else begin
         n_left        = b_item_ff.flags.col_ge1 ? prev_pixel_ff : p;
         n_right       = p;
         n_up          = b_item_ff.flags.tall ? centre : p;
         n_down        = p;
         res.frame_end = 1'b1;
      end
      sum = fnab_pkg::SUM_BITS'(n_left) + fnab_pkg::SUM_BITS'(n_right)
          + fnab_pkg::SUM_BITS'(n_up) + fnab_pkg::SUM_BITS'(n_down);
      res.pixel = sum[fnab_pkg::SUM_BITS-1:fnab_pkg::AVG_SHIFT];
   end

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign take      = b_valid_ff && out_ready && (pending != '0);
   assign remaining = pending & ~(take ? sel_bit : '0);
   assign b_leave   = b_valid_ff && (remaining == '0);

   always_comb begin
      b_valid_in        = b_valid_ff;
      b_item_in         = b_item_ff;
      sent_in           = sent_ff;
      byp_centre_in     = byp_centre_ff;
      byp_above_in      = byp_above_ff;
      byp_right_in      = byp_right_ff;
      byp_centre_val_in = byp_centre_val_ff;
      byp_above_val_in  = byp_above_val_ff;
      byp_right_val_in  = byp_right_val_ff;
      prev_centre_in    = prev_centre_ff;
      prev_pixel_in     = prev_pixel_ff;
      prev2_pixel_in    = prev2_pixel_ff;

      if (take) begin
         sent_in = sent_ff | sel_bit;
      end
      if (b_leave) begin
         b_valid_in     = 1'b0;
         prev_centre_in = centre;
         prev_pixel_in  = p;
         prev2_pixel_in = prev_pixel_ff;
      end
      if (issue) begin
         b_valid_in        = 1'b1;
         b_item_in         = head.item;
         sent_in           = '0;
         // the leaving item writes its column in this same cycle
         byp_centre_in     = b_valid_ff && (head.item.col == b_item_ff.col);
         byp_above_in      = b_valid_ff && (head.item.col == b_item_ff.col);
         byp_right_in      = b_valid_ff && (head_right_addr == b_item_ff.col);
         byp_centre_val_in = p;
         byp_above_val_in  = centre;
         byp_right_val_in  = p;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      b_item_ff         <= b_item_in;
      byp_centre_val_ff <= byp_centre_val_in;
      byp_above_val_ff  <= byp_above_val_in;
      byp_right_val_ff  <= byp_right_val_in;
      prev_centre_ff    <= prev_centre_in;
      prev_pixel_ff     <= prev_pixel_in;
      prev2_pixel_ff    <= prev2_pixel_in;
      rsp_data_ff       <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         sent_ff       <= '0;
         byp_centre_ff <= 1'b0;
         byp_above_ff  <= 1'b0;
         byp_right_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         b_valid_ff    <= b_valid_in;
         sent_ff       <= sent_in;
         byp_centre_ff <= byp_centre_in;
         byp_above_ff  <= byp_above_in;
         byp_right_ff  <= byp_right_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/four_neighbor_average_blur_top.sv
// Streaming four-neighbor blur: source pixels enter in raster order and each
// result is (left + right + up + down) >> 2 over the unblurred frame, with
// border rows and columns repeated. Results come out one row behind the
// input, tagged with row, column and an end-of-frame flag. Pixels are taken
// one per clock on all rows but the last while rsp_stall is low. On the last
// row of a frame two or more rows high, each pixel past column 0 yields two
// results (three on the final pixel), so there the single output register
// holds input until that pixel's results are out; a one-row frame yields one
// result per pixel past column 0 and two on the final one. A result passes
// the queue slot, the engine's item register and the output register before
// it shows on rsp_valid. A four-entry queue separates the pixel counter from
// the line-buffer engine. Line buffers are MAX_WIDTH x 8 RAMs with no reset;
// a frame never reads a column before writing it. csr_ready is always high;
// writing frame_width (index 0) or frame_height (index 1) restarts the frame
// and the user must do so only while the block is idle; nothing enforces it.
module four_neighbor_average_blur_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fnab_pkg::PIXEL_BITS-1:0]     req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fnab_pkg::PIXEL_BITS-1:0]     rsp_pixel_out,
   output logic [fnab_pkg::ROW_BITS-1:0]       rsp_out_row,
   output logic [fnab_pkg::COL_BITS-1:0]       rsp_out_col,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fnab_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fnab_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   fnab_pkg::item_xfer_type q_push, q_head;
   fnab_pkg::result_type    rsp_data;
   logic                    q_full, q_pop;

   fnab_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel_in (req_pixel_in),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .q_push       (q_push)
   );

   fnab_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .full  (q_full),
      .pop   (q_pop),
      .head  (q_head)
   );

   fnab_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_pixel_out = rsp_data.pixel;
   assign rsp_out_row   = rsp_data.row;
   assign rsp_out_col   = rsp_data.col;
   assign rsp_frame_end = rsp_data.frame_end;

endmodule

// File: src/fnab_checker.sv
`include "assert_macros.svh"

module fnab_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [fnab_pkg::PIXEL_BITS-1:0]     rsp_pixel_out,
   input logic [fnab_pkg::ROW_BITS-1:0]       rsp_out_row,
   input logic [fnab_pkg::COL_BITS-1:0]       rsp_out_col,
   input logic                                rsp_frame_end
);

   // a stalled result holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_frame_end), "stalled result changed")

   // the result right after a frame end opens the next frame at the origin
   `ASSERT_NEXT(a_frame_restart, clock, reset, rsp_valid && !rsp_stall && rsp_frame_end, !rsp_valid || (rsp_out_row == '0 && rsp_out_col == '0), "result after frame end not at origin")

   `ASSERT_ALWAYS(a_rsp_reset, clock, $past(reset), !rsp_valid, "result valid right after reset")

   `ASSERT_ALWAYS(a_req_reset, clock, $past(reset), !req_stall, "input stalled right after reset")

endmodule

bind four_neighbor_average_blur_top fnab_checker u_checker (.*);

// File: bench/four_neighbor_average_blur_top_test.sv
module four_neighbor_average_blur_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   // indexes with no register behind them; a write there must not restart the frame
   localparam logic [fnab_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [fnab_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_PIXELS = 260;
   localparam logic [12*fnab_pkg::PIXEL_BITS-1:0] TILE_PX = {
      8'hff, 8'hff, 8'haa, 8'h55, 8'h00, 8'hff, 8'h00, 8'hff,
      8'hff, 8'h00, 8'hff, 8'h00};

   typedef struct {
      logic [fnab_pkg::PIXEL_BITS-1:0] value;
      bit                              drain_first;
   } source_pixel_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [fnab_pkg::PIXEL_BITS-1:0]     req_pixel_in = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [fnab_pkg::PIXEL_BITS-1:0]     rsp_pixel_out;
   logic [fnab_pkg::ROW_BITS-1:0]       rsp_out_row;
   logic [fnab_pkg::COL_BITS-1:0]       rsp_out_col;
   logic                                rsp_frame_end;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [fnab_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [fnab_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   four_neighbor_average_blur_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #4 clock = ~clock;

   // blur predictor state
   logic [fnab_pkg::PIXEL_BITS-1:0]      prior_line [fnab_pkg::MAX_WIDTH];
   logic [fnab_pkg::PIXEL_BITS-1:0]      recent_line [fnab_pkg::MAX_WIDTH];
   int                                   next_row = 0;
   int                                   next_col = 0;
   logic [fnab_pkg::PIXEL_BITS-1:0]      prev_px = '0;
   logic [fnab_pkg::WIDTH_REG_BITS-1:0]  width_reg = fnab_pkg::RESET_FRAME_WIDTH;
   logic [fnab_pkg::HEIGHT_REG_BITS-1:0] height_reg = fnab_pkg::RESET_FRAME_HEIGHT;

   fnab_pkg::result_type pending_blurs[$];
   source_pixel_type     source_pixels[$];

   int  failures = 0;
   int  blurs_checked = 0;
   int  pixels_taken = 0;
   int  size_loads = 0;
   int  send_pct = 0;
   int  stall_pct = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   bit  pixel_sent = 1'b0;

   function automatic int clamp_dim(input int v, input int hi);
      if (v < 1) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void expect_blur(input logic [fnab_pkg::PIXEL_BITS-1:0] l, rt, u, d,
                                       input int row, input int col, input bit is_end);
      fnab_pkg::result_type          r;
      logic [fnab_pkg::SUM_BITS-1:0] sum;
      sum = fnab_pkg::SUM_BITS'(l) + fnab_pkg::SUM_BITS'(rt)
          + fnab_pkg::SUM_BITS'(u) + fnab_pkg::SUM_BITS'(d);
      r.pixel = sum[fnab_pkg::SUM_BITS-1:fnab_pkg::AVG_SHIFT];
      r.row = fnab_pkg::ROW_BITS'(row);
      r.col = fnab_pkg::COL_BITS'(col);
      r.frame_end = is_end;
      pending_blurs.push_back(r);
   endfunction

   function automatic void blur_pixel(input logic [fnab_pkg::PIXEL_BITS-1:0] p);
      int                              w, h, c, r, k;
      logic [fnab_pkg::PIXEL_BITS-1:0] center, above;
      w = clamp_dim(int'(width_reg), fnab_pkg::MAX_WIDTH);
      h = clamp_dim(int'(height_reg), fnab_pkg::MAX_HEIGHT);
      c = (next_col >= w) ? w - 1 : next_col;
      r = (next_row >= h) ? h - 1 : next_row;
      center = recent_line[c];
      above = prior_line[c];
      prior_line[c] = center;
      recent_line[c] = p;
      if (r >= 1)
         expect_blur((c >= 1) ? prior_line[c-1] : center,
                     (c + 1 < w) ? recent_line[c+1] : center,
                     (r >= 2) ? above : center, p, r - 1, c, 1'b0);
      if (r == h - 1) begin
         // last row runs one column behind the input
         if (c >= 1) begin
            k = c - 1;
            expect_blur((k >= 1) ? recent_line[k-1] : prev_px, p,
                        (h >= 2) ? prior_line[k] : prev_px, prev_px, r, k, 1'b0);
         end
         if (c == w - 1)
            expect_blur((c >= 1) ? prev_px : p, p, (h >= 2) ? prior_line[c] : p, p,
                        r, c, 1'b1);
      end
      prev_px = p;
      if (c + 1 >= w) begin
         next_col = 0;
         next_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
         next_row = r;
      end
   endfunction

   function automatic void apply_csr(input logic [fnab_pkg::CSR_INDEX_BITS-1:0] idx,
                                     input logic [fnab_pkg::CSR_DATA_BITS-1:0] data);
      case (idx)
         fnab_pkg::CSR_FRAME_WIDTH: width_reg = data[fnab_pkg::WIDTH_REG_BITS-1:0];
         fnab_pkg::CSR_FRAME_HEIGHT: height_reg = data[fnab_pkg::HEIGHT_REG_BITS-1:0];
         default: return;
      endcase
      next_row = 0;
      next_col = 0;
      prev_px = '0;
   endfunction

   function automatic int pick_gap(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(24, 8);
      return $urandom_range(3, 1);
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(3))
         0: return 0;
         1: return 15;
         2: return 40;
         default: return 70;
      endcase
   endfunction

   function automatic logic [fnab_pkg::PIXEL_BITS-1:0] any_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return fnab_pkg::PIXEL_BITS'($urandom);
      endcase
   endfunction

   // pixel sender
   always @(negedge clock) begin
      source_pixel_type px;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || pixel_sent) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (source_pixels.size() > 0 &&
                      (!source_pixels[0].drain_first || pending_blurs.size() == 0)) begin
            px = source_pixels.pop_front();
            req_pixel_in <= px.value;
            req_valid <= 1'b1;
            gap_left = pick_gap(send_pct);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(negedge clock) begin
      if (stall_left == 0 && !reset) stall_left = pick_gap(stall_pct);
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // transfer monitor: check results, predict from accepted pixels and writes
   always @(posedge clock) begin
      fnab_pkg::result_type got, want;
      if (reset) begin
         pixel_sent <= 1'b0;
      end else begin
         pixel_sent <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            got.pixel = rsp_pixel_out;
            got.row = rsp_out_row;
            got.col = rsp_out_col;
            got.frame_end = rsp_frame_end;
            blurs_checked++;
            if (pending_blurs.size() == 0) begin
               $error("unexpected result at row %0d col %0d", got.row, got.col);
               failures++;
            end else begin
               want = pending_blurs.pop_front();
               if (got.pixel !== want.pixel) begin
                  $error("pixel_out: expected %0d, got %0d", want.pixel, got.pixel);
                  failures++;
               end
               if (got.row !== want.row) begin
                  $error("out_row: expected %0d, got %0d", want.row, got.row);
                  failures++;
               end
               if (got.col !== want.col) begin
                  $error("out_col: expected %0d, got %0d", want.col, got.col);
                  failures++;
               end
               if (got.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            blur_pixel(req_pixel_in);
            pixels_taken++;
         end
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_wdata);
      end
   end

   task automatic write_csr(input logic [fnab_pkg::CSR_INDEX_BITS-1:0] idx, input int value);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= fnab_pkg::CSR_DATA_BITS'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for the block to go idle; row-0 pixels leave nothing to wait on
   task automatic settle();
      do @(posedge clock);
      while (source_pixels.size() != 0 || req_valid || pending_blurs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_frame_size(input int w, input int h);
      settle();
      write_csr(fnab_pkg::CSR_FRAME_WIDTH, w);
      write_csr(fnab_pkg::CSR_FRAME_HEIGHT, h);
      size_loads++;
   endtask

   task automatic queue_random(input int n, input int hold_at);
      for (int i = 0; i < n; i++)
         source_pixels.push_back('{any_pixel(), i == hold_at});
   endtask

   initial begin
      int w, h, n, random_count;
      random_count = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 4x3 tile, split by writes to unused indexes which must not restart it
      load_frame_size(4, 3);
      for (int i = 0; i < 6; i++)
         source_pixels.push_back('{TILE_PX[fnab_pkg::PIXEL_BITS*i +: fnab_pkg::PIXEL_BITS],
                                   1'b0});
      settle();
      write_csr(CSR_SPARE_2, 8191);
      write_csr(CSR_SPARE_3, 0);
      for (int i = 6; i < 12; i++)
         source_pixels.push_back('{TILE_PX[fnab_pkg::PIXEL_BITS*i +: fnab_pkg::PIXEL_BITS],
                                   1'b0});
      send_pct = 30;
      stall_pct = 30;
      load_frame_size(1, 4);
      queue_random(4, -1);
      load_frame_size(3, 1);
      queue_random(3, -1);
      load_frame_size(0, 0);
      queue_random(1, -1);

      // register extremes; width bit 12 falls outside the width register
      send_pct = 10;
      stall_pct = 10;
      load_frame_size(13'h1005, 2);
      queue_random(10, 5);
      load_frame_size(4095, 1);
      queue_random(40, -1);
      load_frame_size(0, 8191);
      queue_random(40, 20);

      // random small frames, some back to back, some cut short
      while (random_count < RANDOM_PIXELS) begin
         w = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         h = $urandom_range(6, 1);
         n = w * h * $urandom_range(2, 1);
         if ($urandom_range(7) == 0 && n > 1) n = $urandom_range(n - 1, 1);
         if (n > RANDOM_PIXELS - random_count) n = RANDOM_PIXELS - random_count;
         send_pct = pick_pct();
         stall_pct = pick_pct();
         load_frame_size(w, h);
         queue_random(n, (random_count == 0 || $urandom_range(2) == 0) ? n / 2 : -1);
         random_count += n;
      end
      settle();

      $display("%0d pixels over %0d frame size loads, %0d blurred pixels checked",
               pixels_taken, size_loads, blurs_checked);
      $display("%0d mismatches", failures);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
